>>> rtl/assert_macros.svh
// Assertion macros used by the keypad scanner checker.
// No dependencies; included by kpd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every rising clock edge outside reset.
`define KPD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define KPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/kpd_pkg.sv
// Package for the keypad scanner: phase type, register indexes, field offsets,
// segment and key maps. No dependencies.
package kpd_pkg;

    localparam int COUNTER_WIDTH_DEF = 16;
    localparam int REG_WIDTH         = 16;
    localparam int CFG_INDEX_WIDTH   = 1;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOCKOUT  = 1'b1;

    localparam logic [REG_WIDTH-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [REG_WIDTH-1:0] LOCKOUT_RST  = 16'd200;

    // Result item layout in tdata, lowest bit up
    localparam int ROW_LSB   = 0;
    localparam int ONES_LSB  = 4;
    localparam int TENS_LSB  = 11;
    localparam int ACC_BIT   = 18;
    localparam int OUT_WIDTH = 24;
    localparam int IN_WIDTH  = 8;

    localparam logic [6:0] SEG_ZERO = 7'h3F;

    typedef enum logic [1:0] {
        PH_SCAN     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_LOCKOUT  = 2'd2
    } phase_t;

    // Seven-segment pattern of one decimal digit, bit0 = a
    function automatic logic [6:0] seg_of(input logic [3:0] digit);
        logic [6:0] seg;
        case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

    // Key value at a row and column; the bottom row gives 0
    function automatic logic [3:0] key_of(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] key;
        case ({row, col})
            4'b00_00: key = 4'd1;
            4'b00_01: key = 4'd2;
            4'b00_10: key = 4'd3;
            4'b01_00: key = 4'd4;
            4'b01_01: key = 4'd5;
            4'b01_10: key = 4'd6;
            4'b10_00: key = 4'd7;
            4'b10_01: key = 4'd8;
            4'b10_10: key = 4'd9;
            default:  key = 4'd0;
        endcase
        return key;
    endfunction

endpackage

>>> rtl/keypad_scan_digit_entry_unit.sv
// Top level of the 4x3 keypad scanner with two-digit entry and segment output.
// Depends on kpd_pkg.
//
// Each input item is one scan tick carrying the three column levels of the row
// shown in that tick's result. One result item comes out per input item, and an
// item is accepted in every cycle: the scan state updates in the accept cycle and
// the result lands in a two-entry output buffer, so input is stalled only when
// both entries are full. Debounce and lockout waits are counted in ticks by a
// COUNTER_WIDTH-bit counter; register values above its range saturate.
module keypad_scan_digit_entry_unit #(
    parameter int COUNTER_WIDTH = kpd_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // config write port
    input  logic                                 cfg_we,
    input  logic [kpd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [kpd_pkg::REG_WIDTH-1:0]        cfg_data,
    // input items
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [kpd_pkg::IN_WIDTH-1:0]         s_axis_tdata,  // [2:0] col_levels
    // result items
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [3:0] row_drive, [10:4] seg_ones, [17:11] seg_tens, [18] key_accepted
    output logic [kpd_pkg::OUT_WIDTH-1:0]        m_axis_tdata
);

    localparam logic [32:0] CNT_MAX = (33'd1 << COUNTER_WIDTH) - 33'd1;

    // config registers
    logic [kpd_pkg::REG_WIDTH-1:0] debounce_reg;
    logic [kpd_pkg::REG_WIDTH-1:0] lockout_reg;

    // scan state
    kpd_pkg::phase_t            phase_reg, phase_next;
    logic [1:0]                 row_reg, row_next;
    logic [1:0]                 held_reg, held_next;
    logic [COUNTER_WIDTH-1:0]   wait_reg, wait_next;
    logic [3:0]                 tens_reg, tens_next;
    logic [3:0]                 ones_reg, ones_next;
    logic                       accepted;

    // output buffer
    logic                              out_valid_reg;
    logic [kpd_pkg::OUT_WIDTH-1:0]     out_data_reg;
    logic                              skid_valid_reg;
    logic [kpd_pkg::OUT_WIDTH-1:0]     skid_data_reg;

    logic                          push, pop;
    logic [2:0]                    cols;
    logic [3:0]                    col_ext;
    logic                          wait_done, recheck_hit;
    logic [2:0]                    scan_first;
    logic                          found;
    logic [1:0]                    found_col;
    logic [COUNTER_WIDTH-1:0]      dbn_load, lock_load;
    logic [kpd_pkg::OUT_WIDTH-1:0] result;

    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign push = s_axis_tvalid && s_axis_tready;
    assign pop  = out_valid_reg && m_axis_tready;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= kpd_pkg::DEBOUNCE_RST;
            lockout_reg  <= kpd_pkg::LOCKOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kpd_pkg::REG_DEBOUNCE: debounce_reg <= cfg_data;
                kpd_pkg::REG_LOCKOUT:  lockout_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // counter loads, saturated to the counter range
    assign dbn_load = ({17'd0, debounce_reg} > CNT_MAX) ? {COUNTER_WIDTH{1'b1}}
                    : COUNTER_WIDTH'({17'd0, debounce_reg});
    assign lock_load = ({17'd0, lockout_reg} > CNT_MAX) ? {COUNTER_WIDTH{1'b1}}
                     : COUNTER_WIDTH'({17'd0, lockout_reg});

    // column checks
    assign cols        = s_axis_tdata[2:0];
    assign col_ext     = {1'b1, cols};
    assign wait_done   = (wait_reg <= COUNTER_WIDTH'(1));
    assign recheck_hit = !col_ext[held_reg];
    assign scan_first  = (phase_reg == kpd_pkg::PH_DEBOUNCE) ? ({1'b0, held_reg} + 3'd1)
                       : 3'd0;

    // lowest low column at or above scan_first
    always_comb
    begin
        found     = 1'b0;
        found_col = 2'd0;
        for (int c = 0; c < 3; c++)
        begin
            if (!found && (3'(c) >= scan_first) && !cols[c])
            begin
                found     = 1'b1;
                found_col = 2'(c);
            end
        end
    end

    // next phase
    always_comb
    begin
        case (phase_reg)
            kpd_pkg::PH_DEBOUNCE:
            begin
                if (!wait_done)
                    phase_next = kpd_pkg::PH_DEBOUNCE;
                else if (recheck_hit)
                    phase_next = (lock_load == '0) ? kpd_pkg::PH_SCAN : kpd_pkg::PH_LOCKOUT;
                else
                    phase_next = found ? kpd_pkg::PH_DEBOUNCE : kpd_pkg::PH_SCAN;
            end
            kpd_pkg::PH_LOCKOUT:
                phase_next = wait_done ? kpd_pkg::PH_SCAN : kpd_pkg::PH_LOCKOUT;
            default:
                phase_next = found ? kpd_pkg::PH_DEBOUNCE : kpd_pkg::PH_SCAN;
        endcase
    end

    // datapath updates for the tick
    always_comb
    begin
        row_next  = row_reg;
        held_next = held_reg;
        wait_next = wait_reg;
        tens_next = tens_reg;
        ones_next = ones_reg;
        accepted  = 1'b0;
        case (phase_reg)
            kpd_pkg::PH_DEBOUNCE:
            begin
                if (!wait_done)
                    wait_next = wait_reg - COUNTER_WIDTH'(1);
                else if (recheck_hit)
                begin
                    // mod 100 entry: ones digit moves up, key becomes ones
                    tens_next = ones_reg;
                    ones_next = kpd_pkg::key_of(row_reg, held_reg);
                    accepted  = 1'b1;
                    wait_next = lock_load;
                    if (lock_load == '0)
                        row_next = 2'd0;
                end
                else if (found)
                begin
                    held_next = found_col;
                    wait_next = dbn_load;
                end
                else
                begin
                    wait_next = '0;
                    row_next  = row_reg + 2'd1;
                end
            end
            kpd_pkg::PH_LOCKOUT:
            begin
                if (!wait_done)
                    wait_next = wait_reg - COUNTER_WIDTH'(1);
                else
                begin
                    wait_next = '0;
                    row_next  = 2'd0;
                end
            end
            default:
            begin
                if (found)
                begin
                    held_next = found_col;
                    wait_next = dbn_load;
                end
                else
                begin
                    wait_next = '0;
                    row_next  = row_reg + 2'd1;
                end
            end
        endcase
    end

    // result item: driven row of this tick, digits after it
    always_comb
    begin
        result = '0;
        result[kpd_pkg::ROW_LSB +: 4]  = ~(4'd1 << row_reg);
        result[kpd_pkg::ONES_LSB +: 7] = kpd_pkg::seg_of(ones_next);
        result[kpd_pkg::TENS_LSB +: 7] = (tens_next == 4'd0) ? 7'd0
                                       : kpd_pkg::seg_of(tens_next);
        result[kpd_pkg::ACC_BIT]       = accepted;
    end

    // scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= kpd_pkg::PH_SCAN;
            row_reg   <= 2'd0;
            held_reg  <= 2'd0;
            wait_reg  <= '0;
            tens_reg  <= 4'd0;
            ones_reg  <= 4'd0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            held_reg  <= held_next;
            wait_reg  <= wait_next;
            tens_reg  <= tens_next;
            ones_reg  <= ones_next;
        end
    end

    // two-entry output buffer: output register plus skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= push;
        end
        else if (push)
        begin
            if (out_valid_reg)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (push)
                out_data_reg <= result;
        end
        else if (push)
        begin
            if (out_valid_reg)
                skid_data_reg <= result;
            else
                out_data_reg <= result;
        end
    end

endmodule

>>> rtl/kpd_checker.sv
// Port-level checks for the keypad scanner, bound to the top level.
// Depends on kpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kpd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [kpd_pkg::OUT_WIDTH-1:0] m_axis_tdata
);

    logic [3:0] row_drive;
    logic [6:0] seg_ones;
    logic       key_acc;

    assign row_drive = m_axis_tdata[kpd_pkg::ROW_LSB +: 4];
    assign seg_ones  = m_axis_tdata[kpd_pkg::ONES_LSB +: 7];
    assign key_acc   = m_axis_tdata[kpd_pkg::ACC_BIT];

    // exactly one row driven low in every result
    `KPD_ASSERT(a_one_row, clk, rst_n, !m_axis_tvalid || $onehot(~row_drive), "row_drive not one-cold")

    // ones digit always shows a lit digit
    `KPD_ASSERT(a_ones_lit, clk, rst_n, !m_axis_tvalid || (seg_ones != 7'd0), "ones digit blank")

    // a key accepted on the bottom row enters a zero
    `KPD_ASSERT(a_bottom_zero, clk, rst_n, !(m_axis_tvalid && key_acc && !row_drive[3]) || (seg_ones == kpd_pkg::SEG_ZERO), "bottom row key not zero")

    // stalled result holds
    `KPD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind keypad_scan_digit_entry_unit kpd_checker u_kpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
